### hdl/cqf_pkg.sv
// ----------------------------------------------------------------------------
// cqf_pkg
// shared sizes, request and status codes, command type for the circular queue
// ----------------------------------------------------------------------------
package cqf_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // request kinds
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_DEQ  = 2'd1;
    localparam logic [1:0] KIND_SHOW = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_cmd;

    // slot index plus one, wrapping at DEPTH
    function automatic logic [IDX_W-1:0] f_advance(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

### hdl/cqf_if.sv
// ----------------------------------------------------------------------------
// cqf_req_if / cqf_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface cqf_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cqf_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

### hdl/cqf_front.sv
// ----------------------------------------------------------------------------
// cqf_front
// accepts requests, drops the unused kind, buffers commands in a two-entry queue
// ----------------------------------------------------------------------------
module cqf_front import cqf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cqf_req_if.sink    i_req,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    logic w_known;
    logic w_push;
    logic w_pop;

    assign i_req.ready = (r_fill != 2'd2);
    assign w_known     = (i_req.kind == KIND_ENQ) || (i_req.kind == KIND_DEQ) ||
                         (i_req.kind == KIND_SHOW);
    assign w_push      = i_req.valid && i_req.ready && w_known;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= '{kind: i_req.kind, value: i_req.value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### hdl/cqf_back.sv
// ----------------------------------------------------------------------------
// cqf_back
// slot store, head/tail/count and the result register; walks the store on display
// ----------------------------------------------------------------------------
module cqf_back import cqf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    cqf_rsp_if.source  o_rsp
);

    logic signed [31:0] r_mem [DEPTH];
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic               r_disp_busy;
    logic [IDX_W-1:0]   r_disp_idx;
    logic [CNT_W-1:0]   r_disp_left;

    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic signed [31:0] r_o_data;
    logic               r_o_last;

    logic               w_load;
    logic               w_empty;
    logic               w_full;
    logic [IDX_W-1:0]   w_idx;
    logic [CNT_W-1:0]   w_left;
    logic               w_show_more;
    logic               w_enq_ok;
    logic               w_deq_ok;

    logic [1:0]         n_status;
    logic               n_last;
    logic               n_rd;
    logic [IDX_W-1:0]   n_rd_addr;

    assign w_load  = i_cmd_valid && (!r_o_valid || o_rsp.ready);
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_idx   = r_disp_busy ? r_disp_idx  : r_head;
    assign w_left  = r_disp_busy ? r_disp_left : r_count;

    assign w_show_more = (i_cmd.kind == KIND_SHOW) && !w_empty && (w_left != CNT_W'(1));
    assign w_enq_ok    = w_load && (i_cmd.kind == KIND_ENQ) && !w_full;
    assign w_deq_ok    = w_load && (i_cmd.kind == KIND_DEQ) && !w_empty;
    assign o_cmd_pop   = w_load && !w_show_more;

    always_comb begin
        n_status  = ST_OK;
        n_last    = 1'b1;
        n_rd      = 1'b0;
        n_rd_addr = r_head;
        unique case (i_cmd.kind)
            KIND_ENQ: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end
            end
            KIND_DEQ: begin
                if (w_empty) begin
                    n_status = ST_UNDER;
                end else begin
                    n_rd = 1'b1;
                end
            end
            KIND_SHOW: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd      = 1'b1;
                    n_rd_addr = w_idx;
                    n_last    = (w_left == CNT_W'(1));
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // slot store and result payload
    always_ff @(posedge i_clk) begin
        if (w_enq_ok) begin
            r_mem[r_tail] <= i_cmd.value;
        end
        if (w_load) begin
            r_o_data   <= n_rd ? r_mem[n_rd_addr] : '0;
            r_o_status <= n_status;
            r_o_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid   <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_disp_busy <= 1'b0;
            r_disp_idx  <= '0;
            r_disp_left <= '0;
        end else begin
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_enq_ok) begin
                r_tail  <= f_advance(r_tail);
                r_count <= r_count + 1'b1;
            end
            if (w_deq_ok) begin
                r_head  <= f_advance(r_head);
                r_count <= r_count - 1'b1;
            end
            if (w_load && w_show_more) begin
                r_disp_busy <= 1'b1;
                r_disp_idx  <= f_advance(w_idx);
                r_disp_left <= w_left - 1'b1;
            end else if (o_cmd_pop) begin
                r_disp_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.valid  = r_o_valid;
    assign o_rsp.status = r_o_status;
    assign o_rsp.data   = r_o_data;
    assign o_rsp.last   = r_o_last;

endmodule

### hdl/circular_queue_fifo_core.sv
// request path: an accepted request is written into the command queue, then loaded
//   from there into the result register, which presents the result
// throughput: one enqueue or dequeue per cycle while results are taken; a display
//   sends its held words one at a time (one result when empty), set by the single read port of the slot store
// reset: head, tail and word count clear to zero, the command queue and result
//   register empty; slot contents stay undefined until written
// ----------------------------------------------------------------------------
// circular_queue_fifo_core
// circular queue of signed 32-bit words with enqueue, dequeue and display requests
// ----------------------------------------------------------------------------
module circular_queue_fifo_core import cqf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cqf_req_if.sink   i_req,
    cqf_rsp_if.source o_rsp
);

    // command handoff between the request side and the queue engine
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    // front: takes every request item, discards the unused kind, and holds up
    // to two commands so the request side keeps moving while results stall
    cqf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // back: owns the slot store and pointers, produces one result item per
    // cycle into its output register while results are taken; a display holds
    // its command until its final word is loaded into that register
    cqf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_rsp       (o_rsp)
    );

    // error results are always single and closing
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> o_rsp.last)
        else $error("error status without last");

    // only ok results carry a word
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.data == '0))
        else $error("error status with non-zero data");

    // no command reaches the engine without a preceding request
    a_cmd_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(w_cmd_valid)) |-> $past(i_req.valid && i_req.ready))
        else $error("command appeared without an accepted request");

    // result register empty straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("result valid after reset");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the circular queue: requests go in on one channel
// and every result is compared field by field against a queue model kept here
// ----------------------------------------------------------------------------
module tb_top import cqf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // kind three is not a request, the block must swallow it silently
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // rough upper bound on the whole run: ~280 requests, up to eight results
    // each, receiver idling 85 % of the time, plus the long hold-off
    localparam int CYCLE_LIMIT  = 200000;
    // settle time once the owed result queue is empty
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } t_rsp_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cqf_req_if req_ch ();
    cqf_rsp_if rsp_ch ();

    circular_queue_fifo_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // queue model: contents, pointers and fill level at the block's widths
    // ------------------------------------------------------------------------
    logic signed [31:0] model_slots [DEPTH];
    logic [IDX_W-1:0]   model_head;
    logic [IDX_W-1:0]   model_tail;
    logic [CNT_W-1:0]   model_count;

    // results still owed by the block, oldest first
    t_rsp_word owed_rsp [$];

    // idling percentages, set by the main sequence and the test tasks
    int send_idle_pct;
    int recv_idle_pct;
    // long receiver hold-off, handed over to the receiver process
    int hold_request;

    // run statistics
    int cycle_count;
    int mismatch_count;
    int results_checked;
    int kind_count [4];
    int full_seen, under_seen, empty_seen, shows_full;
    int stall_run, stall_longest;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return IDX_W'((int'(idx) + 1) % DEPTH);
    endfunction

    // works out the results caused by one accepted request and updates the model
    function automatic void queue_request(input logic [1:0] kind,
                                          input logic signed [31:0] value);
        logic [IDX_W-1:0] idx;
        idx = model_head;
        case (kind)
            KIND_ENQ: begin
                if (int'(model_count) >= DEPTH) begin
                    owed_rsp.push_back('{ST_FULL, 32'sd0, 1'b1});
                end else begin
                    model_slots[model_tail] = value;
                    model_tail  = next_slot(model_tail);
                    model_count = model_count + 1'b1;
                    owed_rsp.push_back('{ST_OK, 32'sd0, 1'b1});
                end
            end
            KIND_DEQ: begin
                if (model_count == '0) begin
                    owed_rsp.push_back('{ST_UNDER, 32'sd0, 1'b1});
                end else begin
                    owed_rsp.push_back('{ST_OK, model_slots[model_head], 1'b1});
                    model_head  = next_slot(model_head);
                    model_count = model_count - 1'b1;
                end
            end
            KIND_SHOW: begin
                if (model_count == '0) begin
                    owed_rsp.push_back('{ST_EMPTY, 32'sd0, 1'b1});
                end else begin
                    // head to tail, last flag on the final word only
                    for (int k = 0; k < int'(model_count); k++) begin
                        owed_rsp.push_back('{ST_OK, model_slots[idx],
                                             (k == int'(model_count) - 1)});
                        idx = next_slot(idx);
                    end
                end
            end
            default: ;  // spare kind: no result, no change of state
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checker and request monitor, both sampling pre-edge values
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp_word want;
        if (i_rst_n) begin
            // results first, so a result can never be matched against a
            // request accepted at the same edge
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_checked++;
                if (owed_rsp.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("[%0t] result with nothing owed:", $realtime,
                                 " status %0d data %0d last %0d",
                                 rsp_ch.status, rsp_ch.data, rsp_ch.last);
                end else begin
                    want = owed_rsp.pop_front();
                    case (want.status)
                        ST_FULL:  full_seen++;
                        ST_UNDER: under_seen++;
                        ST_EMPTY: empty_seen++;
                        default:  ;
                    endcase
                    if (rsp_ch.status !== want.status || rsp_ch.data !== want.data ||
                        rsp_ch.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("[%0t] result differs: want status %0d data %0d",
                                     $realtime, want.status, want.data,
                                     " last %0d, got status %0d data %0d last %0d",
                                     want.last, rsp_ch.status, rsp_ch.data,
                                     rsp_ch.last);
                    end
                end
            end

            if (req_ch.valid && req_ch.ready) begin
                kind_count[req_ch.kind]++;
                if (req_ch.kind == KIND_SHOW && int'(model_count) == DEPTH)
                    shows_full++;
                queue_request(req_ch.kind, req_ch.value);
            end

            // how long the block has kept an offered item waiting
            if (req_ch.valid && !req_ch.ready) begin
                stall_run++;
                if (stall_run > stall_longest)
                    stall_longest = stall_run;
            end else begin
                stall_run = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, or a long hold-off when one is asked for
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] run did not finish within %0d cycles", $realtime, CYCLE_LIMIT);
            $display("circular_queue_fifo_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offers one item and returns at the edge that accepts it, valid left high
    // so a following item can go out back to back
    task automatic send_item(input logic [1:0] kind, input logic signed [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_rsp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // extremes weighted heavily so sign and all-ones patterns turn up often
    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty cases, fill to the brim, overflow, pointer wrap, drain to empty
    task automatic test_directed();
        logic signed [31:0] fill_words [8];
        fill_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678};
        send_item(KIND_DEQ, 32'h0000_0000);     // underflow
        send_item(KIND_SHOW, 32'hFFFF_FFFF);    // display of an empty queue
        foreach (fill_words[i])
            send_item(KIND_ENQ, fill_words[i]);
        send_item(KIND_ENQ, 32'h0BAD_F00D);     // full, must be refused
        send_item(KIND_SHOW, 32'h0000_0000);    // all eight words
        send_item(KIND_SPARE, 32'hFFFF_FFFF);   // ignored
        repeat (3) send_item(KIND_DEQ, random_word());
        send_item(KIND_ENQ, 32'hDEAD_BEEF);     // goes into slot 0, the tail having wrapped with the eighth fill word
        send_item(KIND_ENQ, 32'h8000_0001);
        send_item(KIND_SHOW, 32'h0000_0000);    // display across the wrap
        repeat (7) send_item(KIND_DEQ, random_word());
        drain_results();
    endtask

    // bursts of enqueues and dequeues so the fill level sweeps between empty
    // and full, with displays and the odd spare kind mixed in
    task automatic test_random(input int n_items);
        int         sent;
        int         pick;
        int         burst;
        logic [1:0] base_kind;
        logic [1:0] kind;
        sent = 0;
        while (sent < n_items) begin
            pick  = $urandom_range(0, 9);
            burst = $urandom_range(1, 10);
            if (pick < 4)
                base_kind = KIND_ENQ;
            else if (pick < 8)
                base_kind = KIND_DEQ;
            else begin
                base_kind = KIND_SHOW;
                burst     = 1;
            end
            repeat (burst) begin
                kind = base_kind;
                if ($urandom_range(0, 7) == 0)
                    kind = KIND_SHOW;
                if ($urandom_range(0, 40) == 0)
                    send_item(KIND_SPARE, random_word());   // not counted
                if (sent < n_items) begin
                    send_item(kind, random_word());
                    sent++;
                end
            end
        end
        drain_results();
    endtask

    // receiver holds off for a long stretch while requests keep coming, so
    // results back up, the queue fills and the request side stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 120;
        wait (hold_request == 0);
        repeat (10) send_item(KIND_ENQ, random_word());
        send_item(KIND_SHOW, random_word());
        repeat (10) send_item(KIND_DEQ, random_word());
        send_item(KIND_SHOW, random_word());
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        req_ch.valid   = 1'b0;
        req_ch.kind    = KIND_ENQ;
        req_ch.value   = '0;
        i_rst_n        = 1'b0;
        hold_request   = 0;
        send_idle_pct  = 19;
        recv_idle_pct  = 85;
        mismatch_count = 0;
        model_head     = '0;
        model_tail     = '0;
        model_count    = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // slow receiver first
        test_directed();
        test_random(75);

        // then slow sender
        send_idle_pct = 85;
        recv_idle_pct = 19;
        test_random(75);

        // then full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(75);

        test_backpressure();

        $display("requests: %0d enqueue, %0d dequeue, %0d display, %0d spare;",
                 kind_count[KIND_ENQ], kind_count[KIND_DEQ], kind_count[KIND_SHOW],
                 kind_count[KIND_SPARE], " %0d results checked", results_checked);
        $display("overflow %0d, underflow %0d, empty display %0d, full display %0d,",
                 full_seen, under_seen, empty_seen, shows_full,
                 " longest input stall %0d cycles", stall_longest);
        if (mismatch_count == 0 && owed_rsp.size() == 0) begin
            $display("circular_queue_fifo_core: match");
        end else begin
            $display("circular_queue_fifo_core: mismatch");
        end
        $finish;
    end

endmodule
